### design/bfvt_pkg.sv
`default_nettype none
package bfvt_pkg;

    localparam int DEF_ELEMENT_BITS = 16;
    localparam int LANE_W           = 16;
    localparam int FRAC_BITS        = 8;
    localparam int NUM_CORNERS      = 8;
    localparam int NUM_DIV          = NUM_CORNERS * 3;
    localparam int QUO_BITS         = 16;
    localparam int PROD_W           = 2 * LANE_W;
    localparam int MAT_W            = PROD_W + 2;
    localparam int PNT_W            = LANE_W + 1;
    localparam int MP_W             = MAT_W + PNT_W;
    localparam int VEC_W            = MP_W + 2;
    localparam int NUM_W            = VEC_W + FRAC_BITS;
    localparam int REM_W            = VEC_W + QUO_BITS + 1;
    localparam int CLIP_W           = LANE_W + 1;
    localparam int CFG_IDX_W        = 8;

    localparam logic [63:0] VP_ROW0_RST = 64'd256;
    localparam logic [63:0] VP_ROW1_RST = 64'd16777216;
    localparam logic [63:0] VP_ROW2_RST = 64'd1099511627776;
    localparam logic [63:0] VP_ROW3_RST = 64'd72057594037927936;

    localparam logic signed [CLIP_W-1:0] ONE_FX    = CLIP_W'(1 << FRAC_BITS);
    localparam logic signed [CLIP_W-1:0] START_MIN = CLIP_W'(3 << (FRAC_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VP_ROW0 = 8'd0,
        CFG_VP_ROW1 = 8'd1,
        CFG_VP_ROW2 = 8'd2,
        CFG_VP_ROW3 = 8'd3
    } cfg_idx_t;

    // low eb bits of lane k, sign extended
    function automatic logic signed [LANE_W-1:0] lane(input logic [63:0] word,
                                                      input int k, input int eb);
        logic [LANE_W-1:0] raw;
        logic [LANE_W-1:0] res;
        raw = word[LANE_W*k +: LANE_W];
        for (int b = 0; b < LANE_W; b++) begin
            res[b] = (b < eb) ? raw[b] : raw[eb-1];
        end
        return $signed(res);
    endfunction

endpackage
`default_nettype wire

### design/box_frustum_visibility_test_unit.sv
// Box frustum visibility test.
// Input channel (s_valid/s_ready): one object per request, four packed rows
// of the world transform plus box center and half size, all signed Q8.8.
// Result channel (m_valid/m_ready): one visible bit per object, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): rows 0..3 of the
// view-projection matrix; always ready; the user must write it only while the
// block is idle, which it does not enforce. Pipeline: 23 register stages, one
// request per cycle sustained unless m_ready stalls; the 16 restoring-divide
// steps of the 24 parallel perspective dividers set most of that depth.
// Reset clears all valid bits and loads the identity matrix.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
`default_nettype none
module box_frustum_visibility_test_unit
    import bfvt_pkg::*;
#(
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [63:0]          s_world_row0,
    input  wire logic [63:0]          s_world_row1,
    input  wire logic [63:0]          s_world_row2,
    input  wire logic [63:0]          s_world_row3,
    input  wire logic [47:0]          s_box_center,
    input  wire logic [47:0]          s_box_half_size,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_visible,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int NST  = 7 + QUO_BITS;
    localparam int LAST = NST - 1;
    localparam logic [QUO_BITS-1:0] POS_LIM = QUO_BITS'((1 << (ELEMENT_BITS - 1)) - 1);
    localparam logic [QUO_BITS-1:0] NEG_LIM = QUO_BITS'(1 << (ELEMENT_BITS - 1));
    localparam logic signed [CLIP_W-1:0] Q_MAX = CLIP_W'((1 << (ELEMENT_BITS - 1)) - 1);
    localparam logic signed [CLIP_W-1:0] Q_MIN = -CLIP_W'(1 << (ELEMENT_BITS - 1));

    logic [63:0] vp_reg [4];
    logic [NST-1:0] vld_reg;
    logic en;

    logic signed [PROD_W-1:0] prod_reg [4][4][4];
    logic signed [PNT_W-1:0]  p1_reg [NUM_CORNERS][3];
    logic signed [MAT_W-1:0]  m_reg [4][4];
    logic signed [PNT_W-1:0]  p2_reg [NUM_CORNERS][3];
    logic signed [MP_W-1:0]   mp_reg [NUM_CORNERS][4][3];
    logic signed [MAT_W-1:0]  mt_reg [4];
    logic signed [VEC_W-1:0]  v_reg [NUM_CORNERS][4];

    logic [REM_W-1:0]    rem_reg [QUO_BITS+1][NUM_DIV];
    logic [VEC_W-1:0]    den_reg [QUO_BITS+1][NUM_DIV];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS+1][NUM_DIV];
    logic [3:0]          flg_reg [QUO_BITS+1][NUM_DIV]; // neg, d zero, n pos, ovf

    logic signed [CLIP_W-1:0] clip_reg [NUM_DIV];
    logic vis_reg;

    logic [63:0] world [4];

    assign world[0]  = s_world_row0;
    assign world[1]  = s_world_row1;
    assign world[2]  = s_world_row2;
    assign world[3]  = s_world_row3;
    assign en        = !vld_reg[LAST] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[LAST];
    assign m_visible = vis_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg[0] <= VP_ROW0_RST;
            vp_reg[1] <= VP_ROW1_RST;
            vp_reg[2] <= VP_ROW2_RST;
            vp_reg[3] <= VP_ROW3_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VP_ROW0: vp_reg[0] <= cfg_data;
                CFG_VP_ROW1: vp_reg[1] <= cfg_data;
                CFG_VP_ROW2: vp_reg[2] <= cfg_data;
                CFG_VP_ROW3: vp_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // matrix products and corners
    always_ff @(posedge aclk) begin
        logic signed [PNT_W-1:0] c_ext;
        logic signed [PNT_W-1:0] h_ext;
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    for (int k = 0; k < 4; k++) begin
                        prod_reg[i][j][k] <= PROD_W'(lane(vp_reg[i], k, ELEMENT_BITS))
                                           * PROD_W'(lane(world[k], j, ELEMENT_BITS));
                    end
                end
            end
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int a = 0; a < 3; a++) begin
                    c_ext = PNT_W'(lane({16'd0, s_box_center}, a, ELEMENT_BITS));
                    h_ext = PNT_W'(lane({16'd0, s_box_half_size}, a, ELEMENT_BITS));
                    p1_reg[c][a] <= ((c >> (2 - a)) & 1) != 0 ? c_ext - h_ext
                                                               : c_ext + h_ext;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    m_reg[i][j] <= MAT_W'(prod_reg[i][j][0]) + MAT_W'(prod_reg[i][j][1])
                                 + MAT_W'(prod_reg[i][j][2]) + MAT_W'(prod_reg[i][j][3]);
                end
            end
            p2_reg <= p1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        mp_reg[c][i][j] <= MP_W'(m_reg[i][j]) * MP_W'(p2_reg[c][j]);
                    end
                end
            end
            for (int i = 0; i < 4; i++) begin
                mt_reg[i] <= m_reg[i][3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int i = 0; i < 4; i++) begin
                    v_reg[c][i] <= VEC_W'(mp_reg[c][i][0]) + VEC_W'(mp_reg[c][i][1])
                                 + VEC_W'(mp_reg[c][i][2])
                                 + (VEC_W'(mt_reg[i]) <<< FRAC_BITS);
                end
            end
        end
    end

    // divider setup: magnitudes, flags, overflow when quotient >= 2^16
    always_ff @(posedge aclk) begin
        logic signed [VEC_W-1:0] n;
        logic signed [VEC_W-1:0] d;
        logic [VEC_W-1:0] an;
        logic [VEC_W-1:0] ad;
        if (en) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int a = 0; a < 3; a++) begin
                    n  = v_reg[c][a];
                    d  = v_reg[c][3];
                    an = n[VEC_W-1] ? VEC_W'(-n) : VEC_W'(n);
                    ad = d[VEC_W-1] ? VEC_W'(-d) : VEC_W'(d);
                    rem_reg[0][c*3+a] <= REM_W'(an) << FRAC_BITS;
                    den_reg[0][c*3+a] <= ad;
                    quo_reg[0][c*3+a] <= '0;
                    flg_reg[0][c*3+a] <= {n[VEC_W-1] ^ d[VEC_W-1], d == '0,
                                          !n[VEC_W-1] && n != '0,
                                          NUM_W'(an) >= (NUM_W'(ad) << FRAC_BITS)};
                end
            end
        end
    end

    // restoring division, one quotient bit per stage
    always_ff @(posedge aclk) begin
        logic [REM_W-1:0] cand;
        if (en) begin
            for (int s = 1; s <= QUO_BITS; s++) begin
                for (int e = 0; e < NUM_DIV; e++) begin
                    cand = REM_W'(den_reg[s-1][e]) << (QUO_BITS - s);
                    den_reg[s][e] <= den_reg[s-1][e];
                    flg_reg[s][e] <= flg_reg[s-1][e];
                    if (rem_reg[s-1][e] >= cand) begin
                        rem_reg[s][e] <= rem_reg[s-1][e] - cand;
                        quo_reg[s][e] <= quo_reg[s-1][e] | (QUO_BITS'(1) << (QUO_BITS - s));
                    end else begin
                        rem_reg[s][e] <= rem_reg[s-1][e];
                        quo_reg[s][e] <= quo_reg[s-1][e];
                    end
                end
            end
        end
    end

    // sign and saturation
    always_ff @(posedge aclk) begin
        logic [QUO_BITS-1:0] q;
        logic [3:0] f;
        if (en) begin
            for (int e = 0; e < NUM_DIV; e++) begin
                q = quo_reg[QUO_BITS][e];
                f = flg_reg[QUO_BITS][e];
                if (f[2]) begin
                    clip_reg[e] <= f[1] ? Q_MAX : (f[3] ? Q_MIN : '0);
                end else if (f[3]) begin
                    clip_reg[e] <= (f[0] || q > NEG_LIM) ? Q_MIN : -CLIP_W'(q);
                end else begin
                    clip_reg[e] <= (f[0] || q > POS_LIM) ? Q_MAX : CLIP_W'(q);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [CLIP_W-1:0] lo [3];
        logic signed [CLIP_W-1:0] hi [3];
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                lo[a] = START_MIN;
                hi[a] = -START_MIN;
                for (int c = 0; c < NUM_CORNERS; c++) begin
                    if (clip_reg[c*3+a] < lo[a]) lo[a] = clip_reg[c*3+a];
                    if (clip_reg[c*3+a] > hi[a]) hi[a] = clip_reg[c*3+a];
                end
            end
            vis_reg <= !(lo[2] > ONE_FX || hi[2] < 0
                      || lo[0] > ONE_FX || hi[0] < -ONE_FX
                      || lo[1] > ONE_FX || hi[1] < -ONE_FX);
        end
    end

endmodule
`default_nettype wire
